[sv/cs_pkg.sv]
// ----------------------------------------------------------------------------
// cs_pkg
// Types and constants shared by the comment stripper modules.
// ----------------------------------------------------------------------------
package cs_pkg;

  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam int unsigned MAX_NESTING = 255;
  localparam logic [7:0]  DEPTH_CAP   = (MAX_NESTING < 255) ? 8'(MAX_NESTING) : 8'd255;

  typedef enum logic [2:0] {
    M_NORMAL    = 3'd0,
    M_SLASH     = 3'd1,
    M_LINE      = 3'd2,
    M_BLOCK     = 3'd3,
    M_BLK_STAR  = 3'd4,
    M_BLK_SLASH = 3'd5,
    M_SQUOTE    = 3'd6,
    M_DQUOTE    = 3'd7
  } mode_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } result_t;

  // results produced by one accepted request
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } step_t;

endpackage

[sv/cs_if.sv]
// ----------------------------------------------------------------------------
// cs_in_if / cs_out_if
// Valid/ready channels for source bytes in and stripped bytes out.
// ----------------------------------------------------------------------------
interface cs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_stream;

  modport source (output valid, output in_char, output end_of_stream, input ready);
  modport sink   (input valid, input in_char, input end_of_stream, output ready);
endinterface

interface cs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

[sv/cs_scanner.sv]
// ----------------------------------------------------------------------------
// cs_scanner
// Scan state machine: tracks comment/quote mode and block nesting depth,
// and produces up to two output bytes per accepted request.
// ----------------------------------------------------------------------------
module cs_scanner (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    in_char,
  input  logic          end_of_stream,
  output cs_pkg::step_t step
);
  import cs_pkg::*;

  mode_t      mode, mode_next, mode_scan;
  logic [7:0] depth, depth_next, depth_scan, depth_dec;

  assign depth_dec = (depth != 8'd0) ? depth - 8'd1 : depth;

  // next state
  always_comb begin
    mode_scan  = mode;
    depth_scan = depth;
    unique case (mode)
      M_SLASH: begin
        if (in_char == CH_SLASH) begin
          mode_scan = M_LINE;
        end else if (in_char == CH_STAR) begin
          mode_scan  = M_BLOCK;
          depth_scan = 8'd1;
        end else if (in_char == CH_SQ) begin
          mode_scan = M_SQUOTE;
        end else if (in_char == CH_DQ) begin
          mode_scan = M_DQUOTE;
        end else begin
          mode_scan = M_NORMAL;
        end
      end
      M_LINE: begin
        if (in_char == CH_NL) mode_scan = M_NORMAL;
      end
      M_BLOCK: begin
        if (in_char == CH_STAR) mode_scan = M_BLK_STAR;
        else if (in_char == CH_SLASH) mode_scan = M_BLK_SLASH;
      end
      M_BLK_STAR: begin
        if (in_char == CH_SLASH) begin
          depth_scan = depth_dec;
          mode_scan  = (depth_dec == 8'd0) ? M_NORMAL : M_BLOCK;
        end else if (in_char != CH_STAR) begin
          mode_scan = M_BLOCK;
        end
      end
      M_BLK_SLASH: begin
        if (in_char == CH_STAR) begin
          if (depth < DEPTH_CAP) depth_scan = depth + 8'd1;
          mode_scan = M_BLOCK;
        end else if (in_char != CH_SLASH) begin
          mode_scan = M_BLOCK;
        end
      end
      M_SQUOTE: begin
        if (in_char == CH_SQ) mode_scan = M_NORMAL;
      end
      M_DQUOTE: begin
        if (in_char == CH_DQ) mode_scan = M_NORMAL;
      end
      M_NORMAL: begin
        if (in_char == CH_SLASH) mode_scan = M_SLASH;
        else if (in_char == CH_SQ) mode_scan = M_SQUOTE;
        else if (in_char == CH_DQ) mode_scan = M_DQUOTE;
        else mode_scan = M_NORMAL;
      end
    endcase

    mode_next  = mode_scan;
    depth_next = depth_scan;
    if (end_of_stream) begin
      mode_next  = M_NORMAL;
      depth_next = 8'd0;
    end
  end

  // outputs
  always_comb begin
    step = '0;
    unique case (mode)
      M_SLASH: begin
        if (in_char != CH_SLASH && in_char != CH_STAR) begin
          step.cnt  = 2'd2;
          step.res0 = '{out_char: CH_SLASH, run_last: 1'b0};
          step.res1 = '{out_char: in_char, run_last: 1'b1};
        end
      end
      M_LINE: begin
        if (in_char == CH_NL) begin
          step.cnt  = 2'd1;
          step.res0 = '{out_char: in_char, run_last: 1'b1};
        end
      end
      M_BLOCK, M_BLK_STAR, M_BLK_SLASH: begin
        step.cnt = 2'd0;
      end
      M_SQUOTE, M_DQUOTE: begin
        step.cnt  = 2'd1;
        step.res0 = '{out_char: in_char, run_last: 1'b1};
      end
      M_NORMAL: begin
        step.cnt  = 2'd1;
        step.res0 = '{out_char: in_char, run_last: 1'b1};
        if (in_char == CH_SLASH) begin
          // held slash; emitted here only at end of stream, else with the next byte unless that opens a comment
          step.res0.out_char = CH_SLASH;
          step.cnt           = end_of_stream ? 2'd1 : 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_NORMAL;
      depth <= 8'd0;
    end else if (take) begin
      mode  <= mode_next;
      depth <= depth_next;
    end
  end

endmodule

[sv/comment_stripper_unit.sv]
// ----------------------------------------------------------------------------
// comment_stripper_unit
// Removes line and nested block comments from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   raw   : sink channel, one source byte per request with end_of_stream
//           marking the final byte of a stream.
//   clean : source channel, stripped bytes; run_last flags the last byte
//           produced by a given input request.
// Each request is scanned in the cycle it is accepted and its zero, one or
// two bytes land in a three-entry output queue whose head drives clean.
// Throughput is one request per cycle while each yields at most one byte
// and the receiver keeps up.
// raw.ready is high while the queue holds at most one byte, so a request
// that yields two bytes (a held slash followed by ordinary text) holds off
// the next request even when the receiver keeps up.
// A stalled receiver fills the queue and drops raw.ready; nothing is lost.
// Reset empties the queue and returns the scanner to normal text with zero
// nesting depth. End of stream flushes a held slash and resets the scanner.
// ----------------------------------------------------------------------------
module comment_stripper_unit (
  input logic     clk,
  input logic     rst,
  cs_in_if.sink   raw,
  cs_out_if.source clean
);
  import cs_pkg::*;

  step_t      step;
  result_t    q [3];
  result_t    q_next [3];
  logic [1:0] count, count_next, base;
  logic       take, pop;

  assign raw.ready = (count < 2'd2);
  assign take      = raw.valid && raw.ready;
  assign pop       = clean.valid && clean.ready;

  assign clean.valid    = (count != 2'd0);
  assign clean.out_char = q[0].out_char;
  assign clean.run_last = q[0].run_last;

  cs_scanner u_scanner (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .in_char       (raw.in_char),
    .end_of_stream (raw.end_of_stream),
    .step          (step)
  );

  always_comb begin
    base = count - {1'b0, pop};
    for (int i = 0; i < 3; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      q_next[0] = q[1];
      q_next[1] = q[2];
    end
    count_next = base;
    if (take) begin
      for (int i = 0; i < 3; i++) begin
        if (step.cnt != 2'd0 && 2'(i) == base) q_next[i] = step.res0;
        if (step.cnt == 2'd2 && 2'(i) == base + 2'd1) q_next[i] = step.res1;
      end
      count_next = base + step.cnt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q[i] <= q_next[i];
    end
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for comment_stripper_unit. A queue of source bytes,
// first hand-picked cases and then random text built from quotes, line and
// nested block comments, deep nesting up to saturation and noise, is fed by
// a bursty driver. A scanner model in the bench predicts the stripped bytes
// of every accepted request, and a monitor behind a stalling receiver
// compares them in order.
// ----------------------------------------------------------------------------
module tb;
  import cs_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
    bit         drain;
  } src_byte_t;

  logic clk;
  logic rst;

  cs_in_if  raw_ch();
  cs_out_if clean_ch();

  comment_stripper_unit dut (
    .clk   (clk),
    .rst   (rst),
    .raw   (raw_ch.sink),
    .clean (clean_ch.source)
  );

  src_byte_t raw_pending[$];
  result_t   clean_expected[$];

  mode_t      scan_state;
  logic [7:0] nest_level;
  int         deepest;
  int         errors;
  int         sent_cnt;
  int         checked_cnt;
  int         stream_cnt;
  int         gap_left;
  int         burst_left;
  int         stall_kind;
  int         stall_left;
  int         cyc;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    raw_ch.valid         = 1'b0;
    raw_ch.in_char       = 8'h00;
    raw_ch.end_of_stream = 1'b0;
    clean_ch.ready       = 1'b0;
    scan_state = M_NORMAL;
    nest_level = 8'd0;
    deepest    = 0;
    errors     = 0;
    sent_cnt   = 0;
    checked_cnt = 0;
    stream_cnt = 0;
    gap_left   = 0;
    burst_left = 0;
    stall_kind = 0;
    stall_left = 0;
    cyc        = 0;
  end

  function automatic mode_t after_text(input logic [7:0] c);
    if (c == CH_SQ) return M_SQUOTE;
    if (c == CH_DQ) return M_DQUOTE;
    return M_NORMAL;
  endfunction

  // scanner model: advances state and queues the bytes this request yields
  task automatic strip_predict(input logic [7:0] c, input logic eos);
    logic [7:0] outs[$];
    result_t    r;
    case (scan_state)
      M_SLASH: begin
        if (c == CH_SLASH) begin
          scan_state = M_LINE;
        end else if (c == CH_STAR) begin
          nest_level = 8'd1;
          scan_state = M_BLOCK;
        end else begin
          outs.push_back(CH_SLASH);
          outs.push_back(c);
          scan_state = after_text(c);
        end
      end
      M_LINE: begin
        if (c == CH_NL) begin
          outs.push_back(c);
          scan_state = M_NORMAL;
        end
      end
      M_BLOCK: begin
        if (c == CH_STAR) scan_state = M_BLK_STAR;
        else if (c == CH_SLASH) scan_state = M_BLK_SLASH;
      end
      M_BLK_STAR: begin
        if (c == CH_SLASH) begin
          if (nest_level > 8'd0) nest_level = nest_level - 8'd1;
          scan_state = (nest_level == 8'd0) ? M_NORMAL : M_BLOCK;
        end else if (c != CH_STAR) begin
          scan_state = M_BLOCK;
        end
      end
      M_BLK_SLASH: begin
        if (c == CH_STAR) begin
          if (nest_level < DEPTH_CAP) nest_level = nest_level + 8'd1;
          scan_state = M_BLOCK;
        end else if (c != CH_SLASH) begin
          scan_state = M_BLOCK;
        end
      end
      M_SQUOTE: begin
        outs.push_back(c);
        if (c == CH_SQ) scan_state = M_NORMAL;
      end
      M_DQUOTE: begin
        outs.push_back(c);
        if (c == CH_DQ) scan_state = M_NORMAL;
      end
      default: begin
        if (c == CH_SLASH) begin
          scan_state = M_SLASH;
        end else begin
          outs.push_back(c);
          scan_state = after_text(c);
        end
      end
    endcase
    if (int'(nest_level) > deepest) deepest = int'(nest_level);
    if (eos) begin
      if (scan_state == M_SLASH) outs.push_back(CH_SLASH);
      scan_state = M_NORMAL;
      nest_level = 8'd0;
      stream_cnt++;
    end
    foreach (outs[i]) begin
      r.out_char = outs[i];
      r.run_last = (i == outs.size() - 1);
      clean_expected.push_back(r);
    end
  endtask

  // driver: bursts of requests separated by random gaps
  always @(posedge clk) begin : drive
    src_byte_t nxt;
    logic      next_valid;
    if (rst) begin
      raw_ch.valid <= 1'b0;
    end else begin
      if (raw_ch.valid && raw_ch.ready) begin
        strip_predict(raw_ch.in_char, raw_ch.end_of_stream);
        sent_cnt++;
      end
      if (!raw_ch.valid || raw_ch.ready) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (raw_pending.size() > 0 &&
                     !(raw_pending[0].drain && clean_expected.size() != 0)) begin
          nxt = raw_pending.pop_front();
          raw_ch.in_char       <= nxt.ch;
          raw_ch.end_of_stream <= nxt.eos;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left = 0;
              9:       gap_left = $urandom_range(10, 40);
              default: gap_left = $urandom_range(1, 5);
            endcase
          end
        end
        raw_ch.valid <= next_valid;
      end
    end
  end

  // monitor: receiver with changing stall patterns
  always @(posedge clk) begin : watch
    result_t want;
    logic    rdy;
    cyc++;
    if (rst) begin
      clean_ch.ready <= 1'b0;
    end else begin
      if (clean_ch.valid && clean_ch.ready) begin
        if (clean_expected.size() == 0) begin
          $error("unexpected output: out_char %h run_last %b",
                 clean_ch.out_char, clean_ch.run_last);
          errors++;
        end else begin
          want = clean_expected.pop_front();
          checked_cnt++;
          if (clean_ch.out_char !== want.out_char) begin
            $error("out_char: expected %h actual %h", want.out_char, clean_ch.out_char);
            errors++;
          end
          if (clean_ch.run_last !== want.run_last) begin
            $error("run_last: expected %b actual %b", want.run_last, clean_ch.run_last);
            errors++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_kind = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 300);
      end else begin
        stall_left--;
      end
      case (stall_kind)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 3) != 0);
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = ((cyc % 7) < 3);
      endcase
      clean_ch.ready <= rdy;
    end
  end

  task automatic add_byte(input logic [7:0] c, input logic eos, input bit drain = 1'b0);
    src_byte_t b;
    b.ch    = c;
    b.eos   = eos;
    b.drain = drain;
    raw_pending.push_back(b);
  endtask

  task automatic add_text(input string s, input bit eos_last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], eos_last && (i == s.len() - 1));
  endtask

  // mostly ordinary text, now and then a special byte
  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if ((c == CH_SLASH || c == CH_STAR || c == CH_SQ || c == CH_DQ || c == CH_NL) &&
        $urandom_range(0, 3) != 0)
      c = 8'h61 + 8'($urandom_range(0, 25));
    return c;
  endfunction

  task automatic add_block(input int lvl);
    add_text("/*", 1'b0);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: add_byte(text_byte(), 1'b0);
        5, 6:          add_byte(CH_STAR, 1'b0);
        7:             add_byte(CH_SLASH, 1'b0);
        default: begin
          if (lvl < 4) add_block(lvl + 1);
          else add_byte(text_byte(), 1'b0);
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) add_text("**/", 1'b0);
    else add_text("*/", 1'b0);
  endtask

  task automatic add_random_token();
    logic [7:0] q;
    logic [7:0] c;
    case ($urandom_range(0, 99)) inside
      [0:29]:  repeat ($urandom_range(1, 8)) add_byte(text_byte(), 1'b0);
      [30:39]: begin
        add_byte(CH_SLASH, 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      [40:54]: begin
        add_text("//", 1'b0);
        repeat ($urandom_range(0, 10)) begin
          c = text_byte();
          add_byte((c == CH_NL) ? 8'h20 : c, 1'b0);
        end
        if ($urandom_range(0, 9) != 0) add_byte(CH_NL, 1'b0);
      end
      [55:74]: add_block(0);
      [75:87]: begin
        q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
        add_byte(q, 1'b0);
        repeat ($urandom_range(0, 10)) begin
          c = text_byte();
          add_byte((c == q) ? 8'h78 : c, 1'b0);
        end
        if ($urandom_range(0, 9) != 0) add_byte(q, 1'b0);
      end
      [88:95]: begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 5))
            0:       add_byte(CH_SLASH, 1'b0);
            1:       add_byte(CH_STAR, 1'b0);
            2:       add_byte(CH_SQ, 1'b0);
            3:       add_byte(CH_DQ, 1'b0);
            4:       add_byte(CH_NL, 1'b0);
            default: add_byte(8'($urandom_range(0, 255)), 1'b0);
          endcase
        end
      end
      default: add_byte(8'($urandom_range(0, 255)), 1'b1);
    endcase
  endtask

  initial begin : stimulus
    bit  deep_done;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_text("/'/*'", 1'b0);
    add_text("/\"\"", 1'b0);
    add_text("*/ ", 1'b0);
    add_text("//'\n", 1'b0);
    add_text("/*/**/*/", 1'b0);
    add_text("a/", 1'b1);

    deep_done = 1'b0;
    add_byte(text_byte(), 1'b0, 1'b1);
    while (raw_pending.size() < 1550) begin
      if (!deep_done && raw_pending.size() > 300) begin
        // nesting past the depth cap; one closer fewer than openers ends it
        add_byte(CH_SLASH, 1'b0, 1'b1);
        add_byte(CH_STAR, 1'b0);
        repeat (int'(DEPTH_CAP)) add_text("/*", 1'b0);
        repeat (int'(DEPTH_CAP)) add_text("*/", 1'b0);
        add_text("ok", 1'b0);
        deep_done = 1'b1;
      end
      add_random_token();
    end
    add_byte(8'h2E, 1'b1);

    while (raw_pending.size() != 0 || raw_ch.valid) @(posedge clk);
    while (clean_expected.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("sent %0d bytes in %0d streams, checked %0d output bytes",
             sent_cnt, stream_cnt, checked_cnt);
    $display("deepest block nesting reached: %0d", deepest);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("timeout with %0d outputs outstanding", clean_expected.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
